// ===== rtl/fpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants of the fuzzy PD controller
// Widths of the fixed-point datapath, item codes and controller commands.
// ----------------------------------------------------------------------------
package fpd_pkg;

  localparam int SETS       = 7;
  localparam int DATA_WIDTH = 16;
  localparam int VERTS      = 3;

  localparam int FRAC_BITS   = 8;
  localparam int GRADE_W     = FRAC_BITS + 1;
  localparam int GRADE_ONE   = 1 << FRAC_BITS;
  localparam int GRADE_STEPS = GRADE_W;

  localparam int SET_W      = $clog2(SETS);
  localparam int RULE_DEPTH = SETS * SETS;
  localparam int VTX_DEPTH  = SETS * VERTS;
  localparam int RULE_AW    = $clog2(RULE_DEPTH);
  localparam int VTX_AW     = $clog2(VTX_DEPTH);

  localparam int RULE_W = 8;
  localparam int VAL_W  = 16;
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 15;
  localparam int OUT_W  = 16;

  // Weight is a product of two grades, at most 1.0 * 1.0.
  localparam int W_W    = 2 * GRADE_W - 1;
  localparam int TOP_W  = W_W + RULE_W + $clog2(RULE_DEPTH);
  localparam int BOT_W  = W_W + $clog2(RULE_DEPTH);
  localparam int NUM_W  = TOP_W + GAIN_W + 1;
  localparam int QP_W   = 2 * (VAL_W + 1);
  localparam int CMP_W  = ((DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W) + 1;
  localparam int DEN_W  = ((BOT_W + FRAC_BITS + 2) > CMP_W) ? (BOT_W + FRAC_BITS + 2) : CMP_W;
  localparam int STEP_W = $clog2(NUM_W + 1);

  localparam int CFG_IDX_W = 8;

  typedef enum logic [1:0] {
    KIND_STEP     = 2'd0,
    KIND_RULE     = 2'd1,
    KIND_ERR_VTX  = 2'd2,
    KIND_RATE_VTX = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_GAIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 8'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd256;
  localparam logic [LIM_W-1:0]  LIMIT_RESET = 15'd32767;

  typedef struct packed {
    logic             accept;
    logic             capture;
    logic             quant;
    logic [1:0]       voff;
    logic             latch_a;
    logic             latch_b;
    logic             latch_c;
    logic             sel_rate;
    logic [SET_W-1:0] set_idx;
    logic [SET_W-1:0] col_idx;
    logic             grade_eval;
    logic             grade_div_wr;
    logic             prod_fetch;
    logic             prod_acc;
    logic             final_mul;
    logic             final_start;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic bottom_zero;
  } stat_t;

endpackage

// ===== rtl/fpd_in_if.sv =====
// ----------------------------------------------------------------------------
// fpd_in_if: input channel of the fuzzy PD controller
// Carries control steps and table load words.
// ----------------------------------------------------------------------------
interface fpd_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [15:0]       target;
  logic signed [15:0]       actual;
  logic [7:0]               table_index;
  logic signed [15:0]       table_value;

  modport source (output valid, kind, target, actual, table_index, table_value,
                  input ready);
  modport sink (input valid, kind, target, actual, table_index, table_value,
                output ready);
endinterface

// ===== rtl/fpd_out_if.sv =====
// ----------------------------------------------------------------------------
// fpd_out_if: result channel of the fuzzy PD controller
// Carries the saturated drive and the no-rule flag.
// ----------------------------------------------------------------------------
interface fpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               no_rule_fired;

  modport source (output valid, drive, no_rule_fired, input ready);
  modport sink (input valid, drive, no_rule_fired, output ready);
endinterface

// ===== rtl/fpd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fpd_cfg_if: register write channel of the fuzzy PD controller
// Carries a register index and write data.
// ----------------------------------------------------------------------------
interface fpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/fpd_div.sv =====
// ----------------------------------------------------------------------------
// fpd_div: restoring divider, one quotient bit per cycle
// Shared by the membership grades and the final weighted average.
// ----------------------------------------------------------------------------
module fpd_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [fpd_pkg::DEN_W-1:0]          rem_init,
  input  logic [fpd_pkg::NUM_W-1:0]          num,
  input  logic [fpd_pkg::DEN_W-1:0]          den,
  input  logic [fpd_pkg::STEP_W-1:0]         steps,
  output logic                               done,
  output logic [fpd_pkg::NUM_W-1:0]          quo
);

  logic                          busy;
  logic [fpd_pkg::STEP_W-1:0]    cnt;
  logic [fpd_pkg::DEN_W-1:0]     rem;
  logic [fpd_pkg::NUM_W-1:0]     sh;
  logic [fpd_pkg::DEN_W-1:0]     den_q;
  logic [fpd_pkg::DEN_W:0]       trial;
  logic [fpd_pkg::DEN_W:0]       sub;
  logic                          fits;

  assign trial = {rem, sh[fpd_pkg::NUM_W-1]};
  assign sub   = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == fpd_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      sh    <= num;
      den_q <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= fits ? sub[fpd_pkg::DEN_W-1:0] : trial[fpd_pkg::DEN_W-1:0];
      sh  <= {sh[fpd_pkg::NUM_W-2:0], 1'b0};
      quo <= {quo[fpd_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/fpd_datapath.sv =====
// ----------------------------------------------------------------------------
// fpd_datapath: registers, tables and arithmetic of the fuzzy PD controller
// Error capture, quantizing, grades, rule sums and final scaling.
// ----------------------------------------------------------------------------
module fpd_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  fpd_pkg::cmd_t                     cmd,
  output fpd_pkg::stat_t                    stat,
  input  logic [1:0]                        kind,
  input  logic signed [15:0]                target,
  input  logic signed [15:0]                actual,
  input  logic [7:0]                        table_index,
  input  logic signed [15:0]                table_value,
  input  logic                              cfg_valid,
  input  logic [fpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data,
  output logic signed [fpd_pkg::OUT_W-1:0]  drive,
  output logic                              no_rule_fired
);

  localparam int DW  = fpd_pkg::DATA_WIDTH;
  localparam int CW  = fpd_pkg::CMP_W;
  localparam int QW  = fpd_pkg::QP_W;
  localparam int NW  = fpd_pkg::NUM_W;
  localparam int GW  = fpd_pkg::GRADE_W;
  localparam logic signed [QW-1:0] X_MAX = QW'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] X_MIN = -X_MAX - QW'(1);

  logic [fpd_pkg::GAIN_W-1:0] error_gain, rate_gain, output_gain;
  logic [fpd_pkg::LIM_W-1:0]  output_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_gain   <= fpd_pkg::GAIN_RESET;
      rate_gain    <= fpd_pkg::GAIN_RESET;
      output_gain  <= fpd_pkg::GAIN_RESET;
      output_limit <= fpd_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fpd_pkg::CFG_ERROR_GAIN:   error_gain   <= cfg_data;
        fpd_pkg::CFG_RATE_GAIN:    rate_gain    <= cfg_data;
        fpd_pkg::CFG_OUTPUT_GAIN:  output_gain  <= cfg_data;
        fpd_pkg::CFG_OUTPUT_LIMIT: output_limit <= cfg_data[fpd_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Tables
  logic signed [fpd_pkg::RULE_W-1:0] rule_mem [fpd_pkg::RULE_DEPTH];
  logic signed [fpd_pkg::VAL_W-1:0]  err_vtx  [fpd_pkg::VTX_DEPTH];
  logic signed [fpd_pkg::VAL_W-1:0]  rate_vtx [fpd_pkg::VTX_DEPTH];
  logic signed [fpd_pkg::RULE_W-1:0] rule_q;
  logic signed [fpd_pkg::VAL_W-1:0]  err_vq, rate_vq;
  logic rule_wr, err_wr, rate_wr;
  logic [fpd_pkg::RULE_AW-1:0] rule_addr;
  logic [fpd_pkg::VTX_AW-1:0]  vtx_addr;

  assign rule_wr = cmd.accept && (kind == fpd_pkg::KIND_RULE)
                   && (table_index < 8'(fpd_pkg::RULE_DEPTH));
  assign err_wr  = cmd.accept && (kind == fpd_pkg::KIND_ERR_VTX)
                   && (table_index < 8'(fpd_pkg::VTX_DEPTH));
  assign rate_wr = cmd.accept && (kind == fpd_pkg::KIND_RATE_VTX)
                   && (table_index < 8'(fpd_pkg::VTX_DEPTH));

  assign rule_addr = fpd_pkg::RULE_AW'(fpd_pkg::RULE_AW'(cmd.set_idx)
                     * fpd_pkg::RULE_AW'(fpd_pkg::SETS) + fpd_pkg::RULE_AW'(cmd.col_idx));
  assign vtx_addr  = fpd_pkg::VTX_AW'(fpd_pkg::VTX_AW'(cmd.set_idx)
                     * fpd_pkg::VTX_AW'(fpd_pkg::VERTS) + fpd_pkg::VTX_AW'(cmd.voff));

  always_ff @(posedge clk) begin
    if (rule_wr)
      rule_mem[table_index[fpd_pkg::RULE_AW-1:0]] <= table_value[fpd_pkg::RULE_W-1:0];
    rule_q <= rule_mem[rule_addr];
  end

  always_ff @(posedge clk) begin
    if (err_wr)
      err_vtx[table_index[fpd_pkg::VTX_AW-1:0]] <= table_value;
    if (rate_wr)
      rate_vtx[table_index[fpd_pkg::VTX_AW-1:0]] <= table_value;
    err_vq  <= err_vtx[vtx_addr];
    rate_vq <= rate_vtx[vtx_addr];
  end

  // Error and its change
  logic signed [15:0] prev_error, err_reg;
  logic signed [16:0] rate_reg;
  logic signed [16:0] raw_diff;
  logic signed [15:0] err_sat;

  assign raw_diff = {target[15], target} - {actual[15], actual};
  assign err_sat  = (raw_diff[16] != raw_diff[15]) ?
                    (raw_diff[16] ? 16'sh8000 : 16'sh7fff) : raw_diff[15:0];

  always_ff @(posedge clk) begin
    if (rst)
      prev_error <= '0;
    else if (cmd.capture)
      prev_error <= err_sat;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err_reg  <= err_sat;
      rate_reg <= {err_sat[15], err_sat} - {prev_error[15], prev_error};
    end
  end

  // Quantizing
  logic signed [QW-1:0] prod_e, prod_r;
  logic signed [DW-1:0] xe, xr;

  assign prod_e = QW'(err_reg) * QW'($signed({1'b0, error_gain}));
  assign prod_r = QW'(rate_reg) * QW'($signed({1'b0, rate_gain}));

  always_ff @(posedge clk) begin
    if (cmd.quant) begin
      xe <= (prod_e > X_MAX) ? DW'(X_MAX) : ((prod_e < X_MIN) ? DW'(X_MIN) : DW'(prod_e));
      xr <= (prod_r > X_MAX) ? DW'(X_MAX) : ((prod_r < X_MIN) ? DW'(X_MIN) : DW'(prod_r));
    end
  end

  // Triangle vertices of the set under evaluation
  logic signed [fpd_pkg::VAL_W-1:0] va, vb, vc, vq;
  assign vq = cmd.sel_rate ? rate_vq : err_vq;

  always_ff @(posedge clk) begin
    if (cmd.latch_a) va <= vq;
    if (cmd.latch_b) vb <= vq;
    if (cmd.latch_c) vc <= vq;
  end

  logic signed [CW-1:0] xc, ac, bc, cc;
  logic signed [CW:0]   rise_num, rise_den, fall_num, fall_den;
  logic rise, fall, degen, need_div;
  logic [CW-1:0] gdiff, gden;

  assign xc = CW'(cmd.sel_rate ? xr : xe);
  assign ac = CW'(va);
  assign bc = CW'(vb);
  assign cc = CW'(vc);
  assign rise  = (xc >= ac) && (xc <= bc);
  assign fall  = (xc > bc) && (xc <= cc);
  assign degen = (ac == bc);
  assign need_div = rise ? !degen : fall;
  assign rise_num = (CW+1)'(xc) - (CW+1)'(ac);
  assign rise_den = (CW+1)'(bc) - (CW+1)'(ac);
  assign fall_num = (CW+1)'(cc) - (CW+1)'(xc);
  assign fall_den = (CW+1)'(cc) - (CW+1)'(bc);
  assign gdiff = rise ? rise_num[CW-1:0] : fall_num[CW-1:0];
  assign gden  = rise ? rise_den[CW-1:0] : fall_den[CW-1:0];

  // Grades
  logic [GW-1:0] ge [fpd_pkg::SETS];
  logic [GW-1:0] gr [fpd_pkg::SETS];
  logic [GW-1:0] grade_val;
  logic          grade_wr;
  logic [NW-1:0] quo;
  logic          div_done;

  assign grade_wr  = (cmd.grade_eval && !need_div) || cmd.grade_div_wr;
  assign grade_val = cmd.grade_div_wr ? quo[GW-1:0] :
                     ((rise && degen) ? GW'(fpd_pkg::GRADE_ONE) : '0);

  always_ff @(posedge clk) begin
    if (grade_wr) begin
      if (cmd.sel_rate)
        gr[cmd.set_idx] <= grade_val;
      else
        ge[cmd.set_idx] <= grade_val;
    end
  end

  // Rule sums
  logic [2*GW-1:0]                   w_full;
  logic [fpd_pkg::W_W-1:0]           w_reg;
  logic signed [fpd_pkg::TOP_W-1:0]  term, top;
  logic [fpd_pkg::BOT_W-1:0]         bottom;

  assign w_full = ge[cmd.set_idx] * gr[cmd.col_idx];
  assign term   = fpd_pkg::TOP_W'($signed({1'b0, w_reg})) * fpd_pkg::TOP_W'(rule_q);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      top    <= '0;
      bottom <= '0;
    end else if (cmd.prod_acc) begin
      top    <= top + term;
      bottom <= bottom + fpd_pkg::BOT_W'(w_reg);
    end
    if (cmd.prod_fetch)
      w_reg <= w_full[fpd_pkg::W_W-1:0];
  end

  // Final scaling and rounding division
  logic signed [NW-1:0] q_reg;
  logic                 q_neg;
  logic [NW-1:0]        q_mag, fnum;

  assign q_neg = q_reg[NW-1];
  assign q_mag = q_neg ? NW'(-q_reg) : NW'(q_reg);
  assign fnum  = (q_mag << 1) + NW'({bottom, {fpd_pkg::FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (cmd.final_mul)
      q_reg <= NW'(top) * NW'($signed({1'b0, output_gain}));
  end

  logic                        div_start;
  logic [fpd_pkg::DEN_W-1:0]   div_rem, div_den;
  logic [NW-1:0]               div_num;
  logic [fpd_pkg::STEP_W-1:0]  div_steps;

  assign div_start = (cmd.grade_eval && need_div) || cmd.final_start;
  assign div_rem   = cmd.final_start ? '0 : fpd_pkg::DEN_W'(gdiff >> 1);
  assign div_num   = cmd.final_start ? fnum :
                     {gdiff[0], {fpd_pkg::FRAC_BITS{1'b0}}, {(NW-fpd_pkg::GRADE_STEPS){1'b0}}};
  assign div_den   = cmd.final_start ?
                     fpd_pkg::DEN_W'({bottom, {(fpd_pkg::FRAC_BITS+1){1'b0}}}) :
                     fpd_pkg::DEN_W'(gden);
  assign div_steps = cmd.final_start ? fpd_pkg::STEP_W'(NW) :
                     fpd_pkg::STEP_W'(fpd_pkg::GRADE_STEPS);

  fpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .num      (div_num),
    .den      (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quo      (quo)
  );

  // Output word
  logic [fpd_pkg::LIM_W-1:0] mag;
  assign mag = (quo > NW'(output_limit)) ? output_limit : quo[fpd_pkg::LIM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      no_rule_fired <= stat.bottom_zero;
      if (stat.bottom_zero)
        drive <= '0;
      else
        drive <= q_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign stat.need_div    = need_div;
  assign stat.div_done    = div_done;
  assign stat.bottom_zero = (bottom == '0);

endmodule

// ===== rtl/fpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpd_ctrl: sequencer of the fuzzy PD controller
// Steps the datapath through quantizing, grades, rule sums and scaling.
// ----------------------------------------------------------------------------
module fpd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      kind,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output fpd_pkg::cmd_t   cmd,
  input  fpd_pkg::stat_t  stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_QUANT, S_VA, S_VB, S_VC, S_VD, S_GSET, S_GDIV,
    S_P0, S_P1, S_FMUL, S_FSTART, S_FDIV, S_DONE
  } state_t;

  localparam logic [fpd_pkg::SET_W-1:0] LAST = fpd_pkg::SET_W'(fpd_pkg::SETS - 1);

  state_t                    state;
  logic [fpd_pkg::SET_W-1:0] set_idx, col_idx;
  logic                      sel_rate;
  logic                      accept, out_free, grade_done;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign grade_done = ((state == S_GSET) && !stat.need_div)
                      || ((state == S_GDIV) && stat.div_done);

  always_comb begin
    cmd          = '0;
    cmd.set_idx  = set_idx;
    cmd.col_idx  = col_idx;
    cmd.sel_rate = sel_rate;
    case (state)
      S_IDLE: begin
        cmd.accept  = accept;
        cmd.capture = accept && (kind == fpd_pkg::KIND_STEP);
      end
      S_QUANT:  cmd.quant = 1'b1;
      S_VA:     cmd.voff = 2'd0;
      S_VB: begin
        cmd.voff    = 2'd1;
        cmd.latch_a = 1'b1;
      end
      S_VC: begin
        cmd.voff    = 2'd2;
        cmd.latch_b = 1'b1;
      end
      S_VD:     cmd.latch_c = 1'b1;
      S_GSET:   cmd.grade_eval = 1'b1;
      S_GDIV:   cmd.grade_div_wr = stat.div_done;
      S_P0:     cmd.prod_fetch = 1'b1;
      S_P1:     cmd.prod_acc = 1'b1;
      S_FMUL:   cmd.final_mul = 1'b1;
      S_FSTART: cmd.final_start = !stat.bottom_zero;
      S_DONE:   cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      set_idx   <= '0;
      col_idx   <= '0;
      sel_rate  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        out_valid <= 1'b0;
      // Grades alternate error then rate for each set.
      if (grade_done) begin
        if (!sel_rate) begin
          sel_rate <= 1'b1;
          state    <= S_VA;
        end else begin
          sel_rate <= 1'b0;
          if (set_idx == LAST) begin
            set_idx <= '0;
            col_idx <= '0;
            state   <= S_P0;
          end else begin
            set_idx <= set_idx + 1'b1;
            state   <= S_VA;
          end
        end
      end
      case (state)
        S_IDLE: begin
          if (accept && (kind == fpd_pkg::KIND_STEP)) begin
            set_idx  <= '0;
            sel_rate <= 1'b0;
            state    <= S_QUANT;
          end
        end
        S_QUANT: state <= S_VA;
        S_VA:    state <= S_VB;
        S_VB:    state <= S_VC;
        S_VC:    state <= S_VD;
        S_VD:    state <= S_GSET;
        S_GSET: begin
          if (stat.need_div)
            state <= S_GDIV;
        end
        S_GDIV: ;
        S_P0:    state <= S_P1;
        S_P1: begin
          if (col_idx == LAST) begin
            col_idx <= '0;
            if (set_idx == LAST) begin
              set_idx <= '0;
              state   <= S_FMUL;
            end else begin
              set_idx <= set_idx + 1'b1;
              state   <= S_P0;
            end
          end else begin
            col_idx <= col_idx + 1'b1;
            state   <= S_P0;
          end
        end
        S_FMUL:   state <= S_FSTART;
        S_FSTART: state <= stat.bottom_zero ? S_DONE : S_FDIV;
        S_FDIV: begin
          if (stat.div_done)
            state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/fuzzy_pd_controller.sv =====
// ----------------------------------------------------------------------------
// fuzzy_pd_controller: two-input fuzzy PD controller, triangular sets
// Load words fill the rule table and triangle vertices; a step word
// returns a saturated drive word.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    kind, target, actual, table_index, table_value
//  out_ch   out  valid/ready    drive, no_rule_fired
//  cfg      in   valid/ready    index, data (ready is always high)
//
// A step word passes through quantizing, grades, rule sums and scaling;
// the shared one-bit-per-cycle divider sets the grade and final phases.
// Reset is synchronous; tables are undefined until loaded.
// A finished word waits in the output register while the next word is
// accepted; a step then holds in its last state until the register frees.
module fuzzy_pd_controller (
  input  logic      clk,
  input  logic      rst,
  fpd_in_if.sink    in_ch,
  fpd_out_if.source out_ch,
  fpd_cfg_if.sink   cfg
);

  fpd_pkg::cmd_t  cmd;
  fpd_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  fpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .kind      (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  fpd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (in_ch.kind),
    .target        (in_ch.target),
    .actual        (in_ch.actual),
    .table_index   (in_ch.table_index),
    .table_value   (in_ch.table_value),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .drive         (out_ch.drive),
    .no_rule_fired (out_ch.no_rule_fired)
  );

endmodule
